[sv/stok_pkg.sv]
`default_nettype none
package stok_pkg;
	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_INT, M_FRAC, M_MINUS, M_BANG, M_EQUAL, M_GREATER,
		M_LESS, M_AMP, M_PIPE, M_COMMENT
	} mode_t;

	localparam logic [5:0] K_END = 6'd0, K_UNKNOWN = 6'd1, K_IDENT = 6'd2,
		K_INT = 6'd3, K_FLOAT = 6'd4, K_BOOL = 6'd5, K_NIL = 6'd6, K_KW0 = 6'd7,
		K_PLUS = 6'd15, K_MINUS = 6'd16, K_STAR = 6'd17, K_SLASH = 6'd18,
		K_PERCENT = 6'd19, K_EQUAL = 6'd20, K_EQ_EQ = 6'd21, K_BANG = 6'd22,
		K_BANG_EQ = 6'd23, K_GREATER = 6'd24, K_GREATER_EQ = 6'd25, K_LESS = 6'd26,
		K_LESS_EQ = 6'd27, K_AND_AND = 6'd28, K_OR_OR = 6'd29, K_LPAREN = 6'd30,
		K_RPAREN = 6'd31, K_LBRACE = 6'd32, K_RBRACE = 6'd33, K_COMMA = 6'd34,
		K_SEMICOLON = 6'd35;

	localparam int NWORDS = 11;
	localparam int WORD_CHARS = 8;
	typedef logic [NWORDS-1:0] cand_t;

	// keyword letters, index 0 is the first letter
	function automatic logic [7:0] word_char(input int w, input int i);
		logic [8*WORD_CHARS-1:0] s;
		case (w)
			0: s = {16'h0, "evitan"};
			1: s = "noitcnuf";
			2: s = {32'h0, "tini"};
			3: s = {32'h0, "niam"};
			4: s = {24'h0, "lacol"};
			5: s = {24'h0, "elihw"};
			6: s = {48'h0, "fi"};
			7: s = {32'h0, "esle"};
			8: s = {32'h0, "eurt"};
			9: s = {24'h0, "eslaf"};
			default: s = {40'h0, "lin"};
		endcase
		word_char = s[8*i +: 8];
	endfunction

	function automatic logic [3:0] word_len(input int w);
		case (w)
			0: word_len = 4'd6;
			1: word_len = 4'd8;
			2, 3, 7, 8: word_len = 4'd4;
			4, 5, 9: word_len = 4'd5;
			6: word_len = 4'd2;
			default: word_len = 4'd3;
		endcase
	endfunction
endpackage
`default_nettype wire

[sv/source_tokenizer.sv]
// output: a token appears on the outputs in the cycle after the byte that ends it
// throughput: one byte per cycle unless stalled; a byte may yield two tokens,
// the second held in a spare slot, during which input is stalled
// input is also stalled while a token waits in the output register under stall
// reset: scanner idle, offset 0, line 1, column 1, no token held
`default_nettype none
module source_tokenizer import stok_pkg::*; #(
	parameter int OFFSET_BITS = 20,
	parameter int POSITION_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] ch,
	input wire logic end_of_source,
	output logic out_valid,
	input wire logic out_stall,
	output logic [5:0] kind,
	output logic [OFFSET_BITS-1:0] start_offset,
	output logic [15:0] token_length,
	output logic [POSITION_BITS-1:0] line,
	output logic [POSITION_BITS-1:0] column,
	output logic signed [31:0] value,
	output logic last_of_run
);
	typedef struct packed {
		logic [5:0] kind;
		logic [OFFSET_BITS-1:0] offs;
		logic [15:0] len;
		logic [POSITION_BITS-1:0] line;
		logic [POSITION_BITS-1:0] col;
		logic [31:0] value;
		logic last;
	} tok_t;

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	mode_t mode_q, mode_d;
	logic [OFFSET_BITS-1:0] offs_q, offs_d, tstart_q, tstart_d;
	logic [POSITION_BITS-1:0] line_q, line_d, col_q, col_d, tcol_q, tcol_d;
	logic [15:0] cnt_q, cnt_d;
	cand_t cand_q, cand_d;
	logic [31:0] acc_q, acc_d;
	logic neg_q, neg_d, sat_q, sat_d;

	tok_t out_q, pend_q, t0, t1;
	logic out_v_q, pend_v_q;
	logic n0, n1;

	logic take, out_free;
	assign out_free = !out_v_q || !out_stall;
	assign in_stall = pend_v_q || !out_free;
	assign take = in_valid && !in_stall;

	logic is_dig, is_alp, is_blank;
	assign is_dig = ch >= "0" && ch <= "9";
	assign is_alp = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
	assign is_blank = ch == " " || ch == 8'h09 || ch == 8'h0d || ch == 8'h0a;

	// digit accumulate from a given accumulator/sign state
	function automatic logic [32:0] digit_step(input logic [31:0] a, input logic n,
			input logic s, input logic [7:0] c);
		logic [31:0] lim;
		logic [35:0] nx;
		lim = 32'h7fffffff + {31'b0, n};
		nx = {4'b0, a} * 36'd10 + {32'b0, c[3:0]};
		if (s || nx > {4'b0, lim}) digit_step = {1'b1, lim};
		else digit_step = {1'b0, nx[31:0]};
	endfunction

	// pending token of current mode
	tok_t fl;
	logic fl_v;
	always_comb begin
		logic [5:0] k;
		logic [31:0] v;
		logic hit;
		k = K_IDENT;
		v = '0;
		hit = 1'b0;
		fl_v = 1'b1;
		for (int i = 0; i < NWORDS; i++) begin
			if (!hit && cand_q[i] && cnt_q == {12'b0, word_len(i)}) begin
				hit = 1'b1;
				if (i < 8) k = K_KW0 + 6'(i);
				else if (i == 8) begin k = K_BOOL; v = 32'd1; end
				else if (i == 9) k = K_BOOL;
				else k = K_NIL;
			end
		end
		fl = '{kind: K_UNKNOWN, offs: tstart_q, len: 16'd1, line: line_q,
			col: tcol_q, value: '0, last: 1'b0};
		unique case (mode_q)
			M_IDENT: begin fl.kind = k; fl.len = cnt_q; fl.value = v; end
			M_INT: begin
				fl.kind = K_INT; fl.len = cnt_q;
				fl.value = neg_q ? 32'd0 - acc_q : acc_q;
			end
			M_FRAC: begin fl.kind = K_FLOAT; fl.len = cnt_q; end
			M_MINUS: fl.kind = K_MINUS;
			M_BANG: fl.kind = K_BANG;
			M_EQUAL: fl.kind = K_EQUAL;
			M_GREATER: fl.kind = K_GREATER;
			M_LESS: fl.kind = K_LESS;
			M_AMP, M_PIPE: fl.kind = K_UNKNOWN;
			default: fl_v = 1'b0;
		endcase
	end

	always_comb begin
		logic used, fl_now;
		logic [15:0] cinc;
		logic [32:0] ds;
		logic [5:0] single;
		mode_d = mode_q; offs_d = offs_q; tstart_d = tstart_q; line_d = line_q;
		col_d = col_q; tcol_d = tcol_q; cnt_d = cnt_q; cand_d = cand_q;
		acc_d = acc_q; neg_d = neg_q; sat_d = sat_q;
		used = 1'b0; fl_now = 1'b0;
		n0 = 1'b0; n1 = 1'b0;
		t0 = fl; t1 = fl;
		single = K_UNKNOWN;
		cinc = (cnt_q != 16'hffff) ? cnt_q + 16'd1 : cnt_q;
		ds = digit_step(acc_q, neg_q, sat_q, ch);
		if (end_of_source) begin
			t1 = '{kind: K_END, offs: offs_q, len: 16'd0, line: line_q, col: col_q,
				value: '0, last: 1'b1};
			if (mode_q != M_COMMENT && fl_v) begin n0 = 1'b1; n1 = 1'b1; end
			else begin t0 = t1; n0 = 1'b1; end
			mode_d = M_IDLE; offs_d = '0; line_d = POSITION_BITS'(1);
			col_d = POSITION_BITS'(1); tstart_d = '0; tcol_d = '0; cnt_d = '0;
			cand_d = '0; acc_d = '0; neg_d = 1'b0; sat_d = 1'b0;
		end else begin
			unique case (mode_q)
				M_IDENT:
					if (is_alp || is_dig) begin
						used = 1'b1;
						for (int i = 0; i < NWORDS; i++)
							if (!(cnt_q < {12'b0, word_len(i)} &&
									word_char(i, int'(cnt_q[2:0])) == ch))
								cand_d[i] = 1'b0;
						cnt_d = cinc;
					end else fl_now = 1'b1;
				M_INT:
					if (is_dig) begin
						used = 1'b1; acc_d = ds[31:0]; sat_d = ds[32]; cnt_d = cinc;
					end else if (ch == ".") begin
						used = 1'b1; mode_d = M_FRAC; cnt_d = cinc;
					end else fl_now = 1'b1;
				M_FRAC:
					if (is_dig) begin used = 1'b1; cnt_d = cinc; end
					else fl_now = 1'b1;
				M_MINUS:
					if (ch == "-") begin used = 1'b1; mode_d = M_COMMENT; end
					else if (is_dig) begin
						used = 1'b1; mode_d = M_INT; neg_d = 1'b1;
						ds = digit_step(acc_q, 1'b1, sat_q, ch);
						acc_d = ds[31:0]; sat_d = ds[32]; cnt_d = cinc;
					end else fl_now = 1'b1;
				M_BANG, M_EQUAL, M_GREATER, M_LESS, M_AMP, M_PIPE: begin
					if ((mode_q == M_AMP && ch == "&") || (mode_q == M_PIPE && ch == "|")
							|| (mode_q != M_AMP && mode_q != M_PIPE && ch == "=")) begin
						used = 1'b1; mode_d = M_IDLE; n0 = 1'b1; t0.len = 16'd2;
						unique case (mode_q)
							M_BANG: t0.kind = K_BANG_EQ;
							M_EQUAL: t0.kind = K_EQ_EQ;
							M_GREATER: t0.kind = K_GREATER_EQ;
							M_LESS: t0.kind = K_LESS_EQ;
							M_AMP: t0.kind = K_AND_AND;
							default: t0.kind = K_OR_OR;
						endcase
					end else fl_now = 1'b1;
				end
				M_COMMENT: begin
					used = 1'b1;
					if (ch == 8'h0a) mode_d = M_IDLE;
				end
				default: mode_d = M_IDLE;
			endcase
			if (fl_now) begin n0 = 1'b1; mode_d = M_IDLE; end
			if (!used && !is_blank) begin
				tstart_d = offs_q; tcol_d = col_q; cnt_d = 16'd1; acc_d = '0;
				neg_d = 1'b0; sat_d = 1'b0;
				for (int i = 0; i < NWORDS; i++) cand_d[i] = word_char(i, 0) == ch;
				t1 = '{kind: K_UNKNOWN, offs: offs_q, len: 16'd1, line: line_q,
					col: col_q, value: '0, last: 1'b0};
				mode_d = M_IDLE;
				if (is_dig) begin
					mode_d = M_INT;
					ds = digit_step(32'd0, 1'b0, 1'b0, ch);
					acc_d = ds[31:0]; sat_d = ds[32];
				end else if (is_alp) mode_d = M_IDENT;
				else begin
					case (ch)
						"-": mode_d = M_MINUS;
						"!": mode_d = M_BANG;
						"=": mode_d = M_EQUAL;
						">": mode_d = M_GREATER;
						"<": mode_d = M_LESS;
						"&": mode_d = M_AMP;
						"|": mode_d = M_PIPE;
						"+": single = K_PLUS;
						"*": single = K_STAR;
						"/": single = K_SLASH;
						"%": single = K_PERCENT;
						"(": single = K_LPAREN;
						")": single = K_RPAREN;
						"{": single = K_LBRACE;
						"}": single = K_RBRACE;
						",": single = K_COMMA;
						";": single = K_SEMICOLON;
						default: single = K_UNKNOWN;
					endcase
					if (mode_d == M_IDLE) begin
						t1.kind = single;
						if (n0) n1 = 1'b1;
						else begin t0 = t1; n0 = 1'b1; end
					end
				end
			end
			offs_d = offs_q + OFFSET_BITS'(1);
			if (ch == 8'h0a) begin
				if (line_q != POS_MAX) line_d = line_q + POSITION_BITS'(1);
				col_d = POSITION_BITS'(1);
			end else if (col_q != POS_MAX) col_d = col_q + POSITION_BITS'(1);
			if (n1) t1.last = 1'b1;
			else t0.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; offs_q <= '0; tstart_q <= '0;
			line_q <= POSITION_BITS'(1); col_q <= POSITION_BITS'(1); tcol_q <= '0;
			cnt_q <= '0; cand_q <= '0; acc_q <= '0; neg_q <= 1'b0; sat_q <= 1'b0;
			out_v_q <= 1'b0; pend_v_q <= 1'b0;
		end else begin
			if (take) begin
				mode_q <= mode_d; offs_q <= offs_d; tstart_q <= tstart_d;
				line_q <= line_d; col_q <= col_d; tcol_q <= tcol_d; cnt_q <= cnt_d;
				cand_q <= cand_d; acc_q <= acc_d; neg_q <= neg_d; sat_q <= sat_d;
			end
			if (pend_v_q && out_free) begin
				out_q <= pend_q; out_v_q <= 1'b1; pend_v_q <= 1'b0;
			end else if (take && n0) begin
				out_q <= t0; out_v_q <= 1'b1; pend_q <= t1; pend_v_q <= n1;
			end else if (out_free) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// output register plus one spare slot for a second token
	assign out_valid = out_v_q;
	assign kind = out_q.kind;
	assign start_offset = out_q.offs;
	assign token_length = out_q.len;
	assign line = out_q.line;
	assign column = out_q.col;
	assign value = out_q.value;
	assign last_of_run = out_q.last;
endmodule
`default_nettype wire
